// ===== hdl/pva_pkg.sv =====
// pva_pkg: types and constants of the polyphonic voice allocator
// no dependencies; imported by poly_voice_allocator
package pva_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_OLDEST,
      ST_COMMIT,
      ST_DONE
   } state_type;

   // work done on each voice during a scan
   typedef enum logic [1:0] {
      OP_PICK,
      OP_NOTE_OFF,
      OP_RELEASE,
      OP_CUT
   } op_type;

   // midi message kinds (high nibble of status)
   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
   localparam logic [3:0] KIND_CTRL     = 4'hB;
   localparam logic [3:0] KIND_BEND     = 4'hE;

   // controller numbers
   localparam logic [7:0] CC_MOD_WHEEL     = 8'd1;
   localparam logic [7:0] CC_SUSTAIN       = 8'd64;
   localparam logic [7:0] CC_ALL_SOUND_OFF = 8'd120;
   localparam logic [7:0] CC_RESET_CTRL    = 8'd121;
   localparam logic [7:0] CC_ALL_NOTES_OFF = 8'd123;

   localparam logic [13:0] BEND_CENTER = 14'd8192;
   localparam int          CHANNELS    = 16;

endpackage

// ===== hdl/poly_voice_allocator.sv =====
// poly_voice_allocator: midi voice allocation with stealing, one voice scanned per cycle
// depends on pva_pkg
//
// An item is taken when start is high and busy is low; busy then stays high until its
// single result has been shown on the rsp_ ports for one cycle with rsp_valid, and the
// block is ready again the cycle after. The receiver cannot stall, so rsp_ data must be
// captured in that cycle. Timing is set by the voice scan, which visits one voice per
// cycle through one shared note/channel match and one shared age comparator. With N
// voices (VOICE_COUNT): an envelope report, pitch bend, mod wheel, sustain press,
// unknown message or rejected message shows its result after the decode step alone,
// with no scan; note-off, sustain release, reset controllers, all notes off and all
// sound off show it after one scan over the N voices; a note-on adds a commit step
// after its scan, and a second scan that looks for the oldest voice when every voice
// is held. Masks report voices 0 to 7 only.
module poly_voice_allocator
   import pva_pkg::*;
#(
   parameter int VOICE_COUNT = 8,
   parameter int AGE_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [7:0]  req_status,
   input  logic [7:0]  req_data1,
   input  logic [7:0]  req_data2,
   input  logic [2:0]  req_voice_index,
   output logic        rsp_valid,
   output logic        rsp_started,
   output logic [2:0]  rsp_voice,
   output logic        rsp_voice_was_idle,
   output logic        rsp_lfo_restart,
   output logic [7:0]  rsp_gate_mask,
   output logic [7:0]  rsp_held_mask,
   output logic [7:0]  rsp_active_mask,
   output logic [7:0]  rsp_hard_stop_mask,
   output logic [13:0] rsp_bend_value,
   output logic [6:0]  rsp_mod_value,
   output logic        rsp_sustain_on,
   output logic        rsp_ignored
);

   localparam int IDX_W = $clog2(VOICE_COUNT);
   localparam int PAD_W = (VOICE_COUNT < 8) ? 8 : VOICE_COUNT;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);

   // sequencer
   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // latched request
   logic       cmd_ff, cmd_in;
   logic [3:0] kind_ff, kind_in;
   logic [3:0] ch_ff, ch_in;
   logic [7:0] d1_ff, d1_in;
   logic [7:0] d2_ff, d2_in;
   logic [2:0] vidx_ff, vidx_in;

   // voice table
   logic [VOICE_COUNT-1:0] active_ff, active_in;
   logic [VOICE_COUNT-1:0] held_ff, held_in;
   logic [VOICE_COUNT-1:0] gate_ff, gate_in;
   logic [6:0]          note_ff [VOICE_COUNT];
   logic [6:0]          note_in [VOICE_COUNT];
   logic [3:0]          chan_ff [VOICE_COUNT];
   logic [3:0]          chan_in [VOICE_COUNT];
   logic [AGE_BITS-1:0] vage_ff [VOICE_COUNT];
   logic [AGE_BITS-1:0] vage_in [VOICE_COUNT];
   logic [AGE_BITS-1:0] age_ff, age_in;

   // channel state
   logic [CHANNELS-1:0] sustain_ff, sustain_in;
   logic [13:0] bend_ff [CHANNELS];
   logic [13:0] bend_in [CHANNELS];
   logic [6:0]  mod_ff [CHANNELS];
   logic [6:0]  mod_in [CHANNELS];

   // search registers
   logic                match_found_ff, match_found_in;
   logic [IDX_W-1:0]    match_sel_ff, match_sel_in;
   logic                idle_found_ff, idle_found_in;
   logic [IDX_W-1:0]    idle_sel_ff, idle_sel_in;
   logic                best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]    best_sel_ff, best_sel_in;
   logic [AGE_BITS-1:0] best_age_ff, best_age_in;

   // result registers
   logic                   started_ff, started_in;
   logic [IDX_W-1:0]       sel_ff, sel_in;
   logic                   was_idle_ff, was_idle_in;
   logic                   lfo_ff, lfo_in;
   logic                   ign_ff, ign_in;
   logic [VOICE_COUNT-1:0] stop_ff, stop_in;

   logic accept;

   // decode of the latched message
   logic   dec_scan;
   op_type dec_op;
   logic   sus_press;

   // shared scan unit
   logic                cur_active, cur_held, chan_hit, hit_match, age_less;
   logic                cand, take_best, scan_last;
   logic [6:0]          cur_note;
   logic [3:0]          cur_chan;
   logic [AGE_BITS-1:0] cur_age, age_next;
   logic                match_now, idle_now, best_valid_now, pick_ok;
   logic [IDX_W-1:0]    match_sel_now, idle_sel_now, best_sel_now, pick_sel;

   assign accept = start && !busy;

   // message decode
   always_comb begin
      sus_press = (d1_ff == CC_SUSTAIN) && d2_ff[6];
      dec_scan  = 1'b0;
      dec_op    = OP_PICK;
      if (cmd_ff || d1_ff[7] || d2_ff[7]) begin
         dec_scan = 1'b0;
      end else if (kind_ff == KIND_NOTE_ON && d2_ff != 8'd0) begin
         dec_scan = 1'b1;
         dec_op   = OP_PICK;
      end else if (kind_ff inside {KIND_NOTE_ON, KIND_NOTE_OFF}) begin
         dec_scan = 1'b1;
         dec_op   = OP_NOTE_OFF;
      end else if (kind_ff == KIND_CTRL) begin
         if (d1_ff inside {CC_SUSTAIN, CC_RESET_CTRL}) begin
            dec_scan = !sus_press;
            dec_op   = OP_RELEASE;
         end else if (d1_ff inside {CC_ALL_SOUND_OFF, CC_ALL_NOTES_OFF}) begin
            dec_scan = 1'b1;
            dec_op   = OP_CUT;
         end
      end
   end

   // scan unit: one voice per cycle, one age compare
   always_comb begin
      cur_active = active_ff[idx_ff];
      cur_held   = held_ff[idx_ff];
      cur_note   = note_ff[idx_ff];
      cur_chan   = chan_ff[idx_ff];
      cur_age    = vage_ff[idx_ff];
      chan_hit   = (cur_chan == ch_ff);
      hit_match  = cur_active && (cur_note == d1_ff[6:0]) && chan_hit;
      age_less   = (cur_age < best_age_ff);
      cand       = (state_ff == ST_OLDEST) || !cur_held;
      take_best  = cand && (!best_valid_ff || age_less);
      scan_last  = (idx_ff == LAST_IDX);
      age_next   = (age_ff == '1) ? age_ff : age_ff + AGE_BITS'(1);

      match_now      = match_found_ff || hit_match;
      match_sel_now  = match_found_ff ? match_sel_ff : idx_ff;
      idle_now       = idle_found_ff || !cur_active;
      idle_sel_now   = idle_found_ff ? idle_sel_ff : idx_ff;
      best_valid_now = best_valid_ff || take_best;
      best_sel_now   = take_best ? idx_ff : best_sel_ff;
      pick_ok        = match_now || idle_now || best_valid_now;
      if (match_now) begin
         pick_sel = match_sel_now;
      end else if (idle_now) begin
         pick_sel = idle_sel_now;
      end else begin
         pick_sel = best_sel_now;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = dec_scan ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            if (scan_last) begin
               if (op_ff != OP_PICK) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = pick_ok ? ST_COMMIT : ST_OLDEST;
               end
            end
         end
         ST_OLDEST: begin
            if (scan_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
   end

   // datapath next values
   always_comb begin
      op_in          = op_ff;
      idx_in         = idx_ff;
      cmd_in         = cmd_ff;
      kind_in        = kind_ff;
      ch_in          = ch_ff;
      d1_in          = d1_ff;
      d2_in          = d2_ff;
      vidx_in        = vidx_ff;
      active_in      = active_ff;
      held_in        = held_ff;
      gate_in        = gate_ff;
      note_in        = note_ff;
      chan_in        = chan_ff;
      vage_in        = vage_ff;
      age_in         = age_ff;
      sustain_in     = sustain_ff;
      bend_in        = bend_ff;
      mod_in         = mod_ff;
      match_found_in = match_found_ff;
      match_sel_in   = match_sel_ff;
      idle_found_in  = idle_found_ff;
      idle_sel_in    = idle_sel_ff;
      best_valid_in  = best_valid_ff;
      best_sel_in    = best_sel_ff;
      best_age_in    = best_age_ff;
      started_in     = started_ff;
      sel_in         = sel_ff;
      was_idle_in    = was_idle_ff;
      lfo_in         = lfo_ff;
      ign_in         = ign_ff;
      stop_in        = stop_ff;

      case (state_ff)
         // input transfer: latch request, clear result
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_cmd;
               kind_in     = req_status[7:4];
               ch_in       = req_status[3:0];
               d1_in       = req_data1;
               d2_in       = req_data2;
               vidx_in     = req_voice_index;
               started_in  = 1'b0;
               sel_in      = '0;
               was_idle_in = 1'b0;
               lfo_in      = 1'b0;
               ign_in      = 1'b0;
               stop_in     = '0;
            end
         end

         // messages handled without a scan, and scan setup
         ST_EXEC: begin
            idx_in         = '0;
            op_in          = dec_op;
            match_found_in = 1'b0;
            idle_found_in  = 1'b0;
            best_valid_in  = 1'b0;
            if (cmd_ff) begin
               for (int i = 0; i < VOICE_COUNT; i++) begin
                  if (32'(vidx_ff) == i && !gate_ff[i]) begin
                     active_in[i] = 1'b0;
                     held_in[i]   = 1'b0;
                  end
               end
            end else if (d1_ff[7] || d2_ff[7]) begin
               ign_in = 1'b1;
            end else if (kind_ff == KIND_BEND) begin
               bend_in[ch_ff] = {d2_ff[6:0], d1_ff[6:0]};
            end else if (kind_ff == KIND_NOTE_ON && d2_ff != 8'd0) begin
               lfo_in = ~|held_ff;
            end else if (kind_ff == KIND_CTRL) begin
               if (d1_ff == CC_MOD_WHEEL) begin
                  mod_in[ch_ff] = d2_ff[6:0];
               end else if (d1_ff inside {CC_SUSTAIN, CC_RESET_CTRL}) begin
                  if (d1_ff == CC_RESET_CTRL) begin
                     bend_in[ch_ff] = BEND_CENTER;
                     mod_in[ch_ff]  = '0;
                  end
                  sustain_in[ch_ff] = sus_press;
               end else if (d1_ff inside {CC_ALL_SOUND_OFF, CC_ALL_NOTES_OFF}) begin
                  sustain_in[ch_ff] = 1'b0;
               end
            end
         end

         // per-voice pass
         ST_SCAN: begin
            case (op_ff)
               OP_PICK: begin
                  match_found_in = match_now;
                  match_sel_in   = match_sel_now;
                  idle_found_in  = idle_now;
                  idle_sel_in    = idle_sel_now;
                  if (take_best) begin
                     best_valid_in = 1'b1;
                     best_sel_in   = idx_ff;
                     best_age_in   = cur_age;
                  end
                  if (scan_last) begin
                     sel_in = pick_sel;
                     if (!pick_ok) best_valid_in = 1'b0;
                  end
               end
               OP_NOTE_OFF: begin
                  if (hit_match) begin
                     held_in[idx_ff] = 1'b0;
                     gate_in[idx_ff] = sustain_ff[ch_ff];
                  end
               end
               OP_RELEASE: begin
                  if (chan_hit && !cur_held) gate_in[idx_ff] = 1'b0;
               end
               OP_CUT: begin
                  if (chan_hit) begin
                     held_in[idx_ff] = 1'b0;
                     gate_in[idx_ff] = 1'b0;
                     if (d1_ff == CC_ALL_SOUND_OFF) begin
                        stop_in[idx_ff]   = cur_active;
                        active_in[idx_ff] = 1'b0;
                     end
                  end
               end
               default: begin
                  idx_in = idx_ff;
               end
            endcase
            idx_in = scan_last ? '0 : idx_ff + IDX_W'(1);
         end

         // oldest voice overall, all voices held
         ST_OLDEST: begin
            if (take_best) begin
               best_valid_in = 1'b1;
               best_sel_in   = idx_ff;
               best_age_in   = cur_age;
            end
            if (scan_last) sel_in = best_sel_now;
            idx_in = scan_last ? '0 : idx_ff + IDX_W'(1);
         end

         // claim the chosen voice
         ST_COMMIT: begin
            was_idle_in       = !active_ff[sel_ff];
            active_in[sel_ff] = 1'b1;
            held_in[sel_ff]   = 1'b1;
            gate_in[sel_ff]   = 1'b1;
            note_in[sel_ff]   = d1_ff[6:0];
            chan_in[sel_ff]   = ch_ff;
            age_in            = age_next;
            vage_in[sel_ff]   = age_next;
            started_in        = 1'b1;
         end

         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // control and table registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         active_ff     <= '0;
         held_ff       <= '0;
         gate_ff       <= '0;
         age_ff        <= '0;
         sustain_ff    <= '0;
         for (int i = 0; i < VOICE_COUNT; i++) begin
            note_ff[i] <= '0;
            chan_ff[i] <= '0;
            vage_ff[i] <= '0;
         end
         for (int c = 0; c < CHANNELS; c++) begin
            bend_ff[c] <= BEND_CENTER;
            mod_ff[c]  <= '0;
         end
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         active_ff  <= active_in;
         held_ff    <= held_in;
         gate_ff    <= gate_in;
         age_ff     <= age_in;
         sustain_ff <= sustain_in;
         note_ff    <= note_in;
         chan_ff    <= chan_in;
         vage_ff    <= vage_in;
         bend_ff    <= bend_in;
         mod_ff     <= mod_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      cmd_ff         <= cmd_in;
      kind_ff        <= kind_in;
      ch_ff          <= ch_in;
      d1_ff          <= d1_in;
      d2_ff          <= d2_in;
      vidx_ff        <= vidx_in;
      match_found_ff <= match_found_in;
      match_sel_ff   <= match_sel_in;
      idle_found_ff  <= idle_found_in;
      idle_sel_ff    <= idle_sel_in;
      best_valid_ff  <= best_valid_in;
      best_sel_ff    <= best_sel_in;
      best_age_ff    <= best_age_in;
      started_ff     <= started_in;
      sel_ff         <= sel_in;
      was_idle_ff    <= was_idle_in;
      lfo_ff         <= lfo_in;
      ign_ff         <= ign_in;
      stop_ff        <= stop_in;
   end

   // result ports
   always_comb begin
      logic [PAD_W-1:0] gate_pad, held_pad, active_pad, stop_pad;
      gate_pad           = PAD_W'(gate_ff);
      held_pad           = PAD_W'(held_ff);
      active_pad         = PAD_W'(active_ff);
      stop_pad           = PAD_W'(stop_ff);
      rsp_started        = started_ff;
      rsp_voice          = 3'(sel_ff);
      rsp_voice_was_idle = was_idle_ff;
      rsp_lfo_restart    = lfo_ff;
      rsp_gate_mask      = gate_pad[7:0];
      rsp_held_mask      = held_pad[7:0];
      rsp_active_mask    = active_pad[7:0];
      rsp_hard_stop_mask = stop_pad[7:0];
      rsp_bend_value     = bend_ff[ch_ff];
      rsp_mod_value      = mod_ff[ch_ff];
      rsp_sustain_on     = sustain_ff[ch_ff];
      rsp_ignored        = ign_ff;
   end

`ifndef SYNTHESIS
   // an input transfer always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("input transfer did not start work");

   // the result cycle is followed by the ready state
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (state_ff == ST_IDLE))
      else $error("result not followed by idle");

   // a started voice is live, held and gated when reported
   a_started_live: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && started_ff) |-> (active_ff[sel_ff] && held_ff[sel_ff] && gate_ff[sel_ff]))
      else $error("reported voice not claimed");

   // scan index stays within the voice table
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_IDX)
      else $error("scan index out of range");
`endif

endmodule
